// File: rtl/ddtg_pkg.sv
// Shared constants, types and the arctangent table for the turn-then-go controller.
package ddtg_pkg;

	localparam int CORDIC_STEPS = 14;
	localparam int TAB_LEN      = 24;
	localparam int STEP_W       = $clog2(TAB_LEN + 1);

	localparam int XY_W = 32;
	localparam int Z_W  = 34;

	localparam logic signed [17:0]    PI_Q12      = 18'sd12868;
	localparam logic signed [17:0]    TWO_PI_Q12  = 18'sd25736;
	localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [XY_W-1:0] INV_K_Q30  = 32'sd652032874;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS);

	localparam logic [2:0] REG_TURN_GAIN   = 3'd0;
	localparam logic [2:0] REG_SPEED_GAIN  = 3'd1;
	localparam logic [2:0] REG_ANG_LIMIT   = 3'd2;
	localparam logic [2:0] REG_LIN_LIMIT   = 3'd3;
	localparam logic [2:0] REG_ARRIVE_DIST = 3'd4;
	localparam logic [2:0] REG_ALIGN_TOL   = 3'd5;
	localparam logic [2:0] REG_HALF_TRACK  = 3'd6;

	typedef struct packed {
		logic load;
		logic vectoring;
		logic run;
	} cordic_ctl_t;

	function automatic logic signed [Z_W-1:0] atan_q30(input logic [STEP_W-1:0] idx);
		logic signed [Z_W-1:0] r;
		case (idx)
			5'd0:  r = 34'sd843314857;
			5'd1:  r = 34'sd497837829;
			5'd2:  r = 34'sd263043836;
			5'd3:  r = 34'sd133525158;
			5'd4:  r = 34'sd67021686;
			5'd5:  r = 34'sd33543515;
			5'd6:  r = 34'sd16775850;
			5'd7:  r = 34'sd8388437;
			5'd8:  r = 34'sd4194282;
			5'd9:  r = 34'sd2097149;
			5'd10: r = 34'sd1048575;
			5'd11: r = 34'sd524287;
			5'd12: r = 34'sd262143;
			5'd13: r = 34'sd131071;
			5'd14: r = 34'sd65535;
			5'd15: r = 34'sd32767;
			5'd16: r = 34'sd16383;
			5'd17: r = 34'sd8191;
			5'd18: r = 34'sd4095;
			5'd19: r = 34'sd2047;
			5'd20: r = 34'sd1023;
			5'd21: r = 34'sd511;
			5'd22: r = 34'sd255;
			5'd23: r = 34'sd127;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/ddtg_cordic.sv
// Iterative CORDIC datapath shared by vectoring and rotation.
module ddtg_cordic (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ddtg_pkg::cordic_ctl_t                ctl,
	input  logic signed [ddtg_pkg::XY_W-1:0]     x_init,
	input  logic signed [ddtg_pkg::XY_W-1:0]     y_init,
	input  logic signed [ddtg_pkg::Z_W-1:0]      z_init,
	output logic signed [ddtg_pkg::XY_W-1:0]     x,
	output logic signed [ddtg_pkg::Z_W-1:0]      z,
	output logic                                 done
);
	import ddtg_pkg::*;

	logic signed [XY_W-1:0] x_q, y_q, xs, ys;
	logic signed [Z_W-1:0]  z_q, ang;
	logic [STEP_W-1:0]      step_q;
	logic                   vec_q, pos;

	assign done = (step_q == STEP_LAST);
	assign xs   = x_q >>> step_q;
	assign ys   = y_q >>> step_q;
	assign ang  = atan_q30(step_q);
	assign pos  = vec_q ? ~y_q[XY_W-1] : z_q[Z_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_LAST;
			vec_q  <= 1'b0;
		end else if (ctl.load) begin
			step_q <= '0;
			vec_q  <= ctl.vectoring;
		end else if (ctl.run && !done) begin
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= x_init;
			y_q <= y_init;
			z_q <= z_init;
		end else if (ctl.run && !done) begin
			if (pos) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ang;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ang;
			end
		end
	end

	assign x = x_q;
	assign z = z_q;

endmodule

// File: rtl/diff_drive_turn_then_go_controller.sv
// Turn-then-go differential-drive controller: sequencer, shared multiplier and output.
// One item at a time: a new pose is taken only in idle, once the last result has been handed on.
// Items in the driving phase that have not arrived run the shared CORDIC stage twice, vectoring
// and then rotation; all other items run it once for vectoring. The single shared multiplier
// serves every product in turn.
// Reset: asynchronous, active low; registers to defaults, aligning phase, held speeds zero.
module diff_drive_turn_then_go_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] goal_x,
	input  logic signed [15:0] goal_y,
	input  logic signed [15:0] pose_x,
	input  logic signed [15:0] pose_y,
	input  logic signed [15:0] heading,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] left_speed,
	output logic signed [15:0] right_speed,
	output logic               arrived,
	output logic               driving
);
	import ddtg_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_VEC  = 12'b000000000010,
		S_DIST = 12'b000000000100,
		S_W    = 12'b000000001000,
		S_RWM  = 12'b000000010000,
		S_DEC  = 12'b000000100000,
		S_KVD  = 12'b000001000000,
		S_KVL  = 12'b000010000000,
		S_COS  = 12'b000100000000,
		S_VM   = 12'b001000000000,
		S_FIN  = 12'b010000000000,
		S_OUT  = 12'b100000000000
	} state_t;

	state_t state_q;

	logic [15:0] turn_gain_q, speed_gain_q;
	logic [14:0] ang_limit_q, lin_limit_q, arrive_dist_q, half_track_q;
	logic [13:0] align_tol_q;

	logic               phase_q, arrived_q, zero_q;
	logic signed [15:0] held_left_q, held_right_q, head_q, err_q;
	logic [17:0]        dist_q;
	logic signed [20:0] rw_q;
	logic signed [22:0] kvd_q;
	logic signed [63:0] prod_q;

	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;

	logic signed [16:0] dx, dy;
	logic signed [XY_W-1:0] vx0, vy0, vx, vy, rx, ry, cx, cx_init, cy_init;
	logic signed [Z_W-1:0] vz, rz, rz0, cz, cz_init;
	logic cdone;
	cordic_ctl_t cctl;

	logic signed [Z_W-1:0] zr;
	logic signed [15:0]    bearing;
	logic signed [17:0]    wt0, wt1, wt2;
	logic signed [15:0]    err_n;
	logic [15:0]           err_mag;
	logic signed [18:0]    w_raw;
	logic signed [16:0]    w_n;
	logic signed [20:0]    rw_n;
	logic signed [22:0]    v_raw;
	logic signed [15:0]    v_n;
	logic signed [20:0]    v_ext, v_minus, v_plus;
	logic                  accept;

	function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
		logic signed [15:0] r;
		if (v > 21'sd32767) r = 16'sh7fff;
		else if (v < -21'sd32768) r = 16'sh8000;
		else r = v[15:0];
		return r;
	endfunction

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	// vectoring start values
	assign dx  = 17'(goal_x) - 17'(pose_x);
	assign dy  = 17'(goal_y) - 17'(pose_y);
	assign vx0 = {{5{dx[16]}}, dx, 10'b0};
	assign vy0 = {{5{dy[16]}}, dy, 10'b0};
	always_comb begin
		vx = vx0;
		vy = vy0;
		vz = '0;
		if (vx0[XY_W-1]) begin
			if (!vy0[XY_W-1]) begin
				vx = vy0;
				vy = -vx0;
				vz = HALF_PI_Q30;
			end else begin
				vx = -vy0;
				vy = vx0;
				vz = -HALF_PI_Q30;
			end
		end
	end

	// rotation start values
	assign rz0 = {err_q, 18'b0};
	always_comb begin
		rx = INV_K_Q30;
		ry = '0;
		rz = rz0;
		if (rz0 > HALF_PI_Q30) begin
			rx = '0;
			ry = INV_K_Q30;
			rz = rz0 - HALF_PI_Q30;
		end else if (rz0 < -HALF_PI_Q30) begin
			rx = '0;
			ry = -INV_K_Q30;
			rz = rz0 + HALF_PI_Q30;
		end
	end

	assign cctl.load      = accept || (state_q == S_KVL);
	assign cctl.vectoring = accept;
	assign cctl.run       = (state_q == S_VEC) || (state_q == S_COS);
	assign cx_init        = accept ? vx : rx;
	assign cy_init        = accept ? vy : ry;
	assign cz_init        = accept ? vz : rz;

	ddtg_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cctl),
		.x_init (cx_init),
		.y_init (cy_init),
		.z_init (cz_init),
		.x      (cx),
		.z      (cz),
		.done   (cdone)
	);

	// bearing error wrapped to [-pi, pi)
	assign zr      = cz + (Z_W'(1) <<< 17);
	assign bearing = zero_q ? 16'sd0 : zr[33:18];
	assign wt0     = 18'(bearing) - 18'(head_q) + PI_Q12;
	always_comb begin
		if (wt0 < 0) wt1 = wt0 + TWO_PI_Q12;
		else if (wt0 >= TWO_PI_Q12) wt1 = wt0 - TWO_PI_Q12;
		else wt1 = wt0;
		if (wt1 < 0) wt2 = wt1 + TWO_PI_Q12;
		else if (wt1 >= TWO_PI_Q12) wt2 = wt1 - TWO_PI_Q12;
		else wt2 = wt1;
	end
	assign err_n   = 16'(wt2 - PI_Q12);
	assign err_mag = err_q[15] ? 16'(-err_q) : 16'(err_q);

	// shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_DIST: begin
				mul_a = cx;
				mul_b = INV_K_Q30;
			end
			S_W: begin
				mul_a = 32'($signed({1'b0, turn_gain_q}));
				mul_b = 32'(err_q);
			end
			S_RWM: begin
				mul_a = 32'($signed({1'b0, half_track_q}));
				mul_b = 32'(w_n);
			end
			S_KVD: begin
				mul_a = 32'($signed({1'b0, speed_gain_q}));
				mul_b = 32'($signed({1'b0, dist_q}));
			end
			S_VM: begin
				mul_a = 32'(kvd_q);
				mul_b = cx;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign w_raw = prod_q[30:12];
	always_comb begin
		if (w_raw > $signed({4'b0, ang_limit_q})) w_n = $signed({2'b0, ang_limit_q});
		else if (w_raw < -$signed({4'b0, ang_limit_q})) w_n = -$signed({2'b0, ang_limit_q});
		else w_n = w_raw[16:0];
	end
	assign rw_n   = prod_q[32:12];

	assign v_raw = prod_q[52:30];
	always_comb begin
		if (v_raw > $signed({8'b0, lin_limit_q})) v_n = $signed({1'b0, lin_limit_q});
		else if (v_raw < -$signed({8'b0, lin_limit_q})) v_n = -$signed({1'b0, lin_limit_q});
		else v_n = v_raw[15:0];
	end
	assign v_ext   = 21'(v_n);
	assign v_minus = v_ext - rw_q;
	assign v_plus  = v_ext + rw_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_gain_q   <= 16'd8192;
			speed_gain_q  <= 16'd4096;
			ang_limit_q   <= 15'd16384;
			lin_limit_q   <= 15'd2048;
			arrive_dist_q <= 15'd287;
			align_tol_q   <= 14'd410;
			half_track_q  <= 15'd287;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TURN_GAIN:   turn_gain_q   <= cfg_data;
				REG_SPEED_GAIN:  speed_gain_q  <= cfg_data;
				REG_ANG_LIMIT:   ang_limit_q   <= cfg_data[14:0];
				REG_LIN_LIMIT:   lin_limit_q   <= cfg_data[14:0];
				REG_ARRIVE_DIST: arrive_dist_q <= cfg_data[14:0];
				REG_ALIGN_TOL:   align_tol_q   <= cfg_data[13:0];
				REG_HALF_TRACK:  half_track_q  <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// sequencer and held state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			phase_q      <= 1'b0;
			arrived_q    <= 1'b0;
			held_left_q  <= '0;
			held_right_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_VEC;
				end
				S_VEC: begin
					if (cdone) state_q <= S_DIST;
				end
				S_DIST: state_q <= S_W;
				S_W:    state_q <= S_RWM;
				S_RWM:  state_q <= S_DEC;
				S_DEC: begin
					arrived_q <= 1'b0;
					if (!phase_q) begin
						if (err_mag > {2'b0, align_tol_q}) begin
							held_left_q  <= sat16(-rw_n);
							held_right_q <= sat16(rw_n);
						end else begin
							phase_q <= 1'b1;
						end
						state_q <= S_OUT;
					end else if (dist_q > {3'b0, arrive_dist_q}) begin
						state_q <= S_KVD;
					end else begin
						held_left_q  <= '0;
						held_right_q <= '0;
						arrived_q    <= 1'b1;
						phase_q      <= 1'b0;
						state_q      <= S_OUT;
					end
				end
				S_KVD: state_q <= S_KVL;
				S_KVL: state_q <= S_COS;
				S_COS: begin
					if (cdone) state_q <= S_VM;
				end
				S_VM: state_q <= S_FIN;
				S_FIN: begin
					held_left_q  <= sat16(v_minus);
					held_right_q <= sat16(v_plus);
					state_q      <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			head_q <= heading;
			zero_q <= (dx == 17'sd0) && (dy == 17'sd0);
		end
		if (state_q == S_DIST || state_q == S_W || state_q == S_RWM ||
		    state_q == S_KVD || state_q == S_VM) begin
			prod_q <= mul_p;
		end
		if (state_q == S_DIST) err_q <= err_n;
		if (state_q == S_W) dist_q <= zero_q ? 18'd0 : prod_q[57:40];
		if (state_q == S_DEC) rw_q <= rw_n;
		if (state_q == S_KVL) kvd_q <= prod_q[34:12];
	end

	assign out_valid   = (state_q == S_OUT);
	assign left_speed  = held_left_q;
	assign right_speed = held_right_q;
	assign arrived     = arrived_q;
	assign driving     = phase_q;

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a result is pending");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall && !out_valid)
		else $error("sequencer did not start on accept");
	a_arrive_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && arrived) |-> !driving)
		else $error("arrival left the driving phase set");
	a_arrive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && arrived) |-> (left_speed == 16'sd0 && right_speed == 16'sd0))
		else $error("arrival with nonzero wheel speeds");
`endif

endmodule

// File: tb/diff_drive_turn_then_go_controller_tb.sv
// Testbench for the turn-then-go controller: random poses checked against a cycle-free predictor.
`timescale 1ns / 1ps

module diff_drive_turn_then_go_controller_tb;
	import ddtg_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 60;

	typedef struct {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               arr;
		logic               drv;
	} wheel_cmd_t;

	class wheel_cmd_scoreboard;
		bit [15:0] turn_gain, speed_gain;
		bit [14:0] ang_limit, lin_limit, arrive_dist, half_track;
		bit [13:0] align_tol;
		bit        phase_drv;
		longint    held_l, held_r;
		wheel_cmd_t pending[$];
		int mismatches, checked, arrivals, drive_beats;
		longint atan_q30[24] = '{843314857, 497837829, 263043836, 133525158, 67021686,
			33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
			131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};

		function void reset_state();
			turn_gain = 8192; speed_gain = 4096; ang_limit = 16384; lin_limit = 2048;
			arrive_dist = 287; align_tol = 410; half_track = 287;
			phase_drv = 0; held_l = 0; held_r = 0;
			pending.delete();
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] data);
			case (idx)
				REG_TURN_GAIN:   turn_gain = data;
				REG_SPEED_GAIN:  speed_gain = data;
				REG_ANG_LIMIT:   ang_limit = data[14:0];
				REG_LIN_LIMIT:   lin_limit = data[14:0];
				REG_ARRIVE_DIST: arrive_dist = data[14:0];
				REG_ALIGN_TOL:   align_tol = data[13:0];
				REG_HALF_TRACK:  half_track = data[14:0];
				default: ;
			endcase
		endfunction

		function longint clamp_sym(longint v, longint lim);
			if (v > lim) return lim;
			if (v < -lim) return -lim;
			return v;
		endfunction

		function longint sat16(longint v);
			if (v > 32767) return 32767;
			if (v < -32768) return -32768;
			return v;
		endfunction

		function void polar(longint dx, longint dy, output longint brg, output longint dst);
			longint x, y, z, t, xs, ys;
			x = dx * 1024; y = dy * 1024; z = 0;
			if (dx == 0 && dy == 0) begin
				brg = 0; dst = 0;
				return;
			end
			if (x < 0) begin
				t = x;
				if (y >= 0) begin
					x = y; y = -t; z = HALF_PI_Q30;
				end else begin
					x = -y; y = t; z = -HALF_PI_Q30;
				end
			end
			for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
				xs = x >>> i; ys = y >>> i;
				if (y >= 0) begin
					x += ys; y -= xs; z += atan_q30[i];
				end else begin
					x -= ys; y += xs; z -= atan_q30[i];
				end
			end
			brg = (z + (64'sd1 <<< 17)) >>> 18;
			dst = (x * INV_K_Q30) >>> 40;
		endfunction

		function longint cos_q30(longint e);
			longint x, y, z, xs, ys;
			x = INV_K_Q30; y = 0; z = e * 262144;
			if (z > HALF_PI_Q30) begin
				x = 0; y = INV_K_Q30; z -= HALF_PI_Q30;
			end else if (z < -HALF_PI_Q30) begin
				x = 0; y = -INV_K_Q30; z += HALF_PI_Q30;
			end
			for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
				xs = x >>> i; ys = y >>> i;
				if (z >= 0) begin
					x -= ys; y += xs; z -= atan_q30[i];
				end else begin
					x += ys; y -= xs; z += atan_q30[i];
				end
			end
			return x;
		endfunction

		function void note(logic signed [15:0] gx, gy, px, py, hd);
			longint brg, dst, err, w, rw, mag, kvd, v;
			wheel_cmd_t c;
			polar(longint'(gx) - px, longint'(gy) - py, brg, dst);
			err = (brg - hd + 12868) % 25736;
			if (err < 0) err += 25736;
			err -= 12868;
			w = clamp_sym((longint'(turn_gain) * err) >>> 12, ang_limit);
			rw = (longint'(half_track) * w) >>> 12;
			c.arr = 0;
			if (!phase_drv) begin
				mag = err < 0 ? -err : err;
				if (mag > align_tol) begin
					held_l = sat16(-rw); held_r = sat16(rw);
				end else begin
					phase_drv = 1;
				end
			end else if (dst > arrive_dist) begin
				kvd = (longint'(speed_gain) * dst) >>> 12;
				v = clamp_sym((kvd * cos_q30(err)) >>> 30, lin_limit);
				held_l = sat16(v - rw); held_r = sat16(v + rw);
				drive_beats++;
			end else begin
				held_l = 0; held_r = 0; c.arr = 1; phase_drv = 0;
				arrivals++;
			end
			c.left = held_l[15:0]; c.right = held_r[15:0]; c.drv = phase_drv;
			pending.push_back(c);
		endfunction

		function void check(wheel_cmd_t got);
			wheel_cmd_t exp_c;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: L=%0d R=%0d", got.left, got.right);
				return;
			end
			exp_c = pending.pop_front();
			if (got.left !== exp_c.left || got.right !== exp_c.right ||
			    got.arr !== exp_c.arr || got.drv !== exp_c.drv) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch beat %0d: exp L=%0d R=%0d arr=%0b drv=%0b, ",
						checked, exp_c.left, exp_c.right, exp_c.arr, exp_c.drv,
						"got L=%0d R=%0d arr=%0b drv=%0b",
						got.left, got.right, got.arr, got.drv);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_wr_en = 0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [15:0] goal_x = '0, goal_y = '0, pose_x = '0, pose_y = '0, heading = '0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [15:0] left_speed, right_speed;
	logic arrived, driving;

	wheel_cmd_scoreboard sb;
	int stall_mode = 0;
	bit hold_req = 0;
	int burst_left = 0;
	int items_sent = 0;
	int idle_cycles = 0;
	int cfg_writes = 0;

	diff_drive_turn_then_go_controller u_top (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check('{left_speed, right_speed, arrived, driving});
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver stall pattern
	initial begin
		int cyc;
		cyc = 0;
		forever begin
			@(negedge clk);
			cyc++;
			if (hold_req) begin
				hold_req = 0;
				out_stall = 1;
				repeat (400) @(negedge clk);
			end
			case (stall_mode)
				0: out_stall = 0;
				1: out_stall = ($urandom_range(0, 99) < 30);
				default: out_stall = (cyc % 7) < 3;
			endcase
		end
	end

	task automatic send_beat(logic signed [15:0] gx, gy, px, py, hd);
		if (burst_left == 0) begin
			int gap;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid = 0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		goal_x = gx; goal_y = gy; pose_x = px; pose_y = py; heading = hd;
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		sb.note(gx, gy, px, py, hd);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		cfg_wr_en = 1; cfg_index = idx; cfg_data = data;
		@(posedge clk);
		sb.write_reg(idx, data);
		cfg_writes++;
		@(negedge clk);
		cfg_wr_en = 0;
	endtask

	task automatic write_all(logic [15:0] tg, sg, al, ll, ad, tol, ht);
		write_reg(REG_TURN_GAIN, tg);
		write_reg(REG_SPEED_GAIN, sg);
		write_reg(REG_ANG_LIMIT, al);
		write_reg(REG_LIN_LIMIT, ll);
		write_reg(REG_ARRIVE_DIST, ad);
		write_reg(REG_ALIGN_TOL, tol);
		write_reg(REG_HALF_TRACK, ht);
	endtask

	function automatic logic signed [15:0] facing(int gx, gy, px, py, int noise);
		longint brg, dst;
		sb.polar(gx - px, gy - py, brg, dst);
		return 16'(brg + noise);
	endfunction

	// approach one goal: spin, align, drive in, arrive
	task automatic approach();
		int gx, gy, px, py, ox, oy, steps, span, nz;
		span = ($urandom_range(0, 3) == 0) ? 12000 : 3000;
		gx = $urandom_range(0, 40000) - 20000;
		gy = $urandom_range(0, 40000) - 20000;
		ox = $urandom_range(0, 2 * span) - span;
		oy = $urandom_range(0, 2 * span) - span;
		steps = $urandom_range(3, 10);
		for (int s = 0; s <= steps + 1; s++) begin
			px = gx - (s >= steps ? 0 : ox * (steps - s) / steps);
			py = gy - (s >= steps ? 0 : oy * (steps - s) / steps);
			if (s == 0 && $urandom_range(0, 1))
				nz = $urandom_range(0, 25000) - 12500;
			else
				nz = $urandom_range(0, 800) - 400;
			if ($urandom_range(0, 9) == 0) nz += ($urandom_range(0, 1) ? 25736 : -25736);
			send_beat(16'(gx), 16'(gy), 16'(px), 16'(py), facing(gx, gy, px, py, nz));
		end
	endtask

	task automatic noise_beat();
		send_beat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic random_run(int n);
		int target;
		target = items_sent + n;
		while (items_sent < target) begin
			if ($urandom_range(0, 4) == 0) noise_beat();
			else approach();
		end
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// extremes and special cases at defaults
		send_beat(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000);
		send_beat(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_beat(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh0000);
		send_beat(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'shFFFF);
		send_beat(16'sh1234, 16'sh1234, 16'sh1234, 16'sh1234, 16'sh0000);
		send_beat(-16'sd4000, 16'sd100, 16'sd0, 16'sd0, 16'sd0);
		send_beat(-16'sd4000, -16'sd100, 16'sd0, 16'sd0, 16'sd0);
		send_beat(16'sd8000, 16'sd8000, 16'sd0, 16'sd0, facing(8000, 8000, 0, 0, 0));
		send_beat(16'sd8000, 16'sd8000, 16'sd0, 16'sd0, facing(8000, 8000, 0, 0, 300));
		send_beat(16'sd8000, 16'sd8000, 16'sd7900, 16'sd7950, 16'sd0);
		send_beat(16'sd0, 16'sd4000, 16'sd0, 16'sd0, facing(0, 4000, 0, 0, -30000));
		send_beat(16'sd0, -16'sd4000, 16'sd0, 16'sd0, facing(0, -4000, 0, 0, 0));
		send_beat(16'sd0, -16'sd4000, 16'sd0, 16'sd0, 16'sd0);
		drain();

		// largest gains and limits: wide sums saturate
		write_all(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'd12868, 16'h7FFF);
		send_beat(16'sd20000, 16'sd0, -16'sd12000, 16'sd0, 16'sd6000);
		send_beat(16'sd20000, 16'sd0, -16'sd12000, 16'sd0, 16'sd6000);
		send_beat(16'sd20000, 16'sd0, -16'sd12000, 16'sd0, -16'sd6000);
		send_beat(16'sd20000, 16'sd0, 16'sd20000, 16'sd0, 16'sd0);
		stall_mode = 1;
		random_run(150);
		drain();

		// all zero, then unused index and masked writes
		write_all(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		write_reg(REG_UNUSED, 16'hFFFF);
		stall_mode = 2;
		random_run(150);
		drain();

		write_all(16'h9000, 16'h3000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8123);
		write_reg(REG_UNUSED, 16'h0000);
		stall_mode = 0;
		random_run(100);
		drain();

		// long receiver hold-off while input keeps coming
		write_all(16'd8192, 16'd4096, 16'd16384, 16'd2048, 16'd287, 16'd410, 16'd287);
		hold_req = 1;
		random_run(30);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			write_all(16'($urandom), 16'($urandom), 16'($urandom_range(0, 32767)),
				16'($urandom_range(0, 32767)), 16'($urandom_range(0, 2000)),
				16'($urandom_range(0, 12868)), 16'($urandom_range(0, 32767)));
			stall_mode = ph % 3;
			random_run(130);
			drain();
		end
		write_all(16'd8192, 16'd4096, 16'd16384, 16'd2048, 16'd287, 16'd410, 16'd287);
		stall_mode = 1;
		random_run(100);
		drain();

		$display("run: %0d poses, %0d register writes, %0d driving beats, %0d arrivals",
			items_sent, cfg_writes, sb.drive_beats, sb.arrivals);
		$display("checked %0d result beats, %0d mismatches", sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// File: diff_drive_turn_then_go_controller.f
rtl/ddtg_pkg.sv
rtl/ddtg_cordic.sv
rtl/diff_drive_turn_then_go_controller.sv
tb/diff_drive_turn_then_go_controller_tb.sv
